// ----- src/rca_pkg.sv -----
// rca_pkg: shared types and codes for the ring cell allocator
// no dependencies; used by every module of the block
`timescale 1ns / 1ps
package rca_pkg;

   typedef enum logic [1:0] {
      CELL_FREE        = 2'd0,
      CELL_INSIDE      = 2'd1,
      CELL_END         = 2'd2,
      CELL_PREV_IN_USE = 2'd3
   } cell_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_SPACE  = 2'd1,
      ST_ZERO_SIZE = 2'd2,
      ST_RANGE     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      MODE_ALLOC = 2'd0,
      MODE_FREE  = 2'd1,
      MODE_RESET = 2'd2,
      MODE_NOP   = 2'd3
   } op_type;

   localparam int SIZE_W  = 11;
   localparam int INDEX_W = 10;

   // classified request handed from front to back
   typedef struct packed {
      op_type              op;
      status_type          status;
      logic [SIZE_W-1:0]   size;
      logic [INDEX_W-1:0]  idx;
   } cmd_type;

   // back-end status seen by the front
   typedef struct packed {
      logic clearing;
   } back_stat_type;

endpackage

// ----- src/ring_cell_allocator.sv -----
// ring_cell_allocator: top level of the ring allocator over a pool of cells
// depends on rca_pkg, rca_front, rca_queue, rca_engine
`timescale 1ns / 1ps
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | tdata: alloc_size, free_index; tuser: mode
//  rsp     | out | rsp_tvalid/rsp_tready | tdata: start_index, status
//  csr     | in  | csr_wr_en             | csr_wr_data: pool_size
//
//  allocate: one cell written per cycle after two checks
//  free: each cell of the run and of the trailing in-use cells is a read then a
//  write through the one memory port
//  reset pool, and the clearing pass after reset: req_tready low
//  a two-entry queue keeps taking requests while a result waits on rsp_tready
module ring_cell_allocator #(
   parameter int MAX_CELLS = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // [10:0] alloc_size, [20:11] free_index
   input  logic [1:0]   req_tuser,   // [1:0] mode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata,   // [9:0] start_index, [11:10] status
   input  logic         csr_wr_en,
   input  logic [10:0]  csr_wr_data  // pool_size
);
   localparam int IW = $clog2(MAX_CELLS);
   localparam int SW = $clog2(MAX_CELLS + 1);
   localparam int CW = (SW > rca_pkg::SIZE_W) ? SW : rca_pkg::SIZE_W;

   logic [10:0]              pool_ff;
   logic [SW-1:0]            eff_size;
   rca_pkg::back_stat_type   back_stat;
   rca_pkg::cmd_type         f_cmd, q_cmd;
   logic                     f_valid, f_ready, q_valid, q_ready;

   // pool size register, reset to the full 1024 cells
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff <= 11'd1024;
      end else if (csr_wr_en) begin
         pool_ff <= csr_wr_data;
      end
   end

   // effective size: pool size clamped to 1..MAX_CELLS
   always_comb begin
      if (CW'(pool_ff) > CW'(MAX_CELLS)) begin
         eff_size = SW'(MAX_CELLS);
      end else if (pool_ff == '0) begin
         eff_size = SW'(1);
      end else begin
         eff_size = SW'(CW'(pool_ff));
      end
   end

   rca_front #(.SW(SW)) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .eff_size   (eff_size),
      .back_stat  (back_stat),
      .cmd_valid  (f_valid),
      .cmd_ready  (f_ready),
      .cmd        (f_cmd)
   );

   rca_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_cmd    (f_cmd),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_cmd   (q_cmd)
   );

   rca_engine #(.MAX_CELLS(MAX_CELLS), .IW(IW), .SW(SW)) u_engine (
      .clock      (clock),
      .reset      (reset),
      .eff_size   (eff_size),
      .cmd_valid  (q_valid),
      .cmd_ready  (q_ready),
      .cmd        (q_cmd),
      .back_stat  (back_stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );
endmodule

// ----- src/rca_front.sv -----
// rca_front: accepts requests and classifies them (operation, early errors)
// depends on rca_pkg
`timescale 1ns / 1ps
module rca_front #(
   parameter int SW = 11
) (
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [23:0]              req_tdata,
   input  logic [1:0]               req_tuser,
   input  logic [SW-1:0]            eff_size,
   input  rca_pkg::back_stat_type   back_stat,
   output logic                     cmd_valid,
   input  logic                     cmd_ready,
   output rca_pkg::cmd_type         cmd
);
   localparam int CW = (SW > rca_pkg::SIZE_W) ? SW : rca_pkg::SIZE_W;

   logic [CW-1:0] size_w;
   logic [CW-1:0] idx_w;
   logic [CW-1:0] p_w;

   assign size_w = CW'(req_tdata[10:0]);
   assign idx_w  = CW'(req_tdata[20:11]);
   assign p_w    = CW'(eff_size);

   assign req_tready = cmd_ready && !back_stat.clearing;
   assign cmd_valid  = req_tvalid && !back_stat.clearing;

   always_comb begin
      cmd.op     = rca_pkg::op_type'(req_tuser);
      cmd.size   = req_tdata[10:0];
      cmd.idx    = req_tdata[20:11];
      cmd.status = rca_pkg::ST_OK;
      unique case (rca_pkg::op_type'(req_tuser))
         rca_pkg::MODE_ALLOC: begin
            if (size_w > p_w) begin
               cmd.status = rca_pkg::ST_NO_SPACE;
            end else if (size_w == '0) begin
               cmd.status = rca_pkg::ST_ZERO_SIZE;
            end
         end
         rca_pkg::MODE_FREE: begin
            if (idx_w >= p_w) begin
               cmd.status = rca_pkg::ST_RANGE;
            end
         end
         default: begin
            cmd.status = rca_pkg::ST_OK;
         end
      endcase
   end
endmodule

// ----- src/rca_queue.sv -----
// rca_queue: two-entry queue of classified requests between front and back
// depends on rca_pkg
`timescale 1ns / 1ps
module rca_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  rca_pkg::cmd_type   in_cmd,
   output logic               out_valid,
   input  logic               out_ready,
   output rca_pkg::cmd_type   out_cmd
);
   rca_pkg::cmd_type ent_ff [2];
   rca_pkg::cmd_type ent_in [2];
   logic [1:0]       cnt_ff, cnt_in;
   logic             push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_cmd   = ent_ff[0];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      ent_in[0] = ent_ff[0];
      ent_in[1] = ent_ff[1];
      cnt_in    = cnt_ff;
      if (pop) begin
         ent_in[0] = ent_ff[1];
      end
      if (push) begin
         if (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && pop)) begin
            ent_in[0] = in_cmd;
         end else if (pop) begin
            ent_in[1] = in_cmd;
         end else begin
            ent_in[1] = in_cmd;
         end
      end
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      ent_ff[0] <= ent_in[0];
      ent_ff[1] <= ent_in[1];
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end
endmodule

// ----- src/rca_engine.sv -----
// rca_engine: cell memory and sequencer that carries out allocate, free and clear
// depends on rca_pkg
`timescale 1ns / 1ps
module rca_engine #(
   parameter int MAX_CELLS = 1024,
   parameter int IW        = 10,
   parameter int SW        = 11
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [SW-1:0]            eff_size,
   input  logic                     cmd_valid,
   output logic                     cmd_ready,
   input  rca_pkg::cmd_type         cmd,
   output rca_pkg::back_stat_type   back_stat,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [15:0]              rsp_tdata
);
   localparam int AW = SW + 1;
   localparam int CW = (SW > rca_pkg::SIZE_W) ? SW : rca_pkg::SIZE_W;

   typedef enum logic [12:0] {
      S_CLEAR = 13'h0001,
      S_IDLE  = 13'h0002,
      S_ARDL  = 13'h0004,
      S_ARDF  = 13'h0008,
      S_ACHK  = 13'h0010,
      S_AMARK = 13'h0020,
      S_FPREV = 13'h0040,
      S_FCHK  = 13'h0080,
      S_FRD   = 13'h0100,
      S_FWR   = 13'h0200,
      S_TRD   = 13'h0400,
      S_TWR   = 13'h0800,
      S_RESP  = 13'h1000
   } state_type;

   rca_pkg::cell_type mem [MAX_CELLS];
   rca_pkg::cell_type rdata_ff;

   state_type              state_ff, state_in;
   logic [IW-1:0]          cur_ff, cur_in;
   logic [IW-1:0]          last_ff, last_in;
   logic [IW-1:0]          next_ff, next_in;
   logic [SW-1:0]          cnt_ff, cnt_in;
   rca_pkg::cell_type      mark_ff, mark_in;
   logic                   lfree_ff, lfree_in;
   logic                   pend_ff, pend_in;
   logic [9:0]             res_start_ff, res_start_in;
   rca_pkg::status_type    res_stat_ff, res_stat_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [9:0]             rsp_start_ff, rsp_start_in;
   rca_pkg::status_type    rsp_stat_ff, rsp_stat_in;

   logic                   we;
   logic [IW-1:0]          waddr, raddr;
   rca_pkg::cell_type      wdata;
   logic [IW-1:0]          cur_wrap;
   logic [SW-1:0]          cnt_inc;
   logic [SW-1:0]          sz;
   logic [AW-1:0]          end_sum;

   assign cur_wrap = ((SW'(cur_ff) + SW'(1)) == eff_size) ? '0 : cur_ff + IW'(1);
   assign cnt_inc  = cnt_ff + SW'(1);
   assign sz       = SW'(CW'(cmd.size));
   assign end_sum  = AW'(next_ff) + AW'(sz);

   assign back_stat.clearing = (state_ff == S_CLEAR);
   assign cmd_ready  = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_stat_ff, rsp_start_ff};

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      last_in      = last_ff;
      next_in      = next_ff;
      cnt_in       = cnt_ff;
      mark_in      = mark_ff;
      lfree_in     = lfree_ff;
      pend_in      = pend_ff;
      res_start_in = res_start_ff;
      res_stat_in  = res_stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_start_in = rsp_start_ff;
      rsp_stat_in  = rsp_stat_ff;
      we           = 1'b0;
      waddr        = cur_ff;
      wdata        = rca_pkg::CELL_FREE;
      raddr        = cur_ff;
      unique case (state_ff)
         S_CLEAR: begin
            we      = 1'b1;
            next_in = '0;
            if (cur_ff == IW'(MAX_CELLS - 1)) begin
               state_in = pend_ff ? S_RESP : S_IDLE;
               pend_in  = 1'b0;
            end else begin
               cur_in = cur_ff + IW'(1);
            end
         end
         S_IDLE: begin
            if (cmd_valid) begin
               res_start_in = '0;
               res_stat_in  = cmd.status;
               unique case (cmd.op)
                  rca_pkg::MODE_ALLOC: begin
                     if (cmd.status != rca_pkg::ST_OK) begin
                        state_in = S_RESP;
                     end else begin
                        if (AW'(next_ff) >= AW'(eff_size) || end_sum > AW'(eff_size)) begin
                           cur_in  = '0;
                           last_in = IW'(sz - SW'(1));
                        end else begin
                           cur_in  = next_ff;
                           last_in = IW'(end_sum - AW'(1));
                        end
                        state_in = S_ARDL;
                     end
                  end
                  rca_pkg::MODE_FREE: begin
                     cur_in   = IW'(CW'(cmd.idx));
                     state_in = (cmd.status != rca_pkg::ST_OK) ? S_RESP : S_FPREV;
                  end
                  rca_pkg::MODE_RESET: begin
                     cur_in   = '0;
                     pend_in  = 1'b1;
                     state_in = S_CLEAR;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_ARDL: begin
            raddr    = last_ff;
            state_in = S_ARDF;
         end
         S_ARDF: begin
            raddr    = cur_ff;
            lfree_in = (rdata_ff == rca_pkg::CELL_FREE);
            state_in = S_ACHK;
         end
         S_ACHK: begin
            if (lfree_ff && rdata_ff == rca_pkg::CELL_FREE) begin
               res_start_in = 10'(cur_ff);
               state_in     = S_AMARK;
            end else begin
               res_stat_in = rca_pkg::ST_NO_SPACE;
               state_in    = S_RESP;
            end
         end
         S_AMARK: begin
            we = 1'b1;
            if (cur_ff == last_ff) begin
               wdata    = rca_pkg::CELL_END;
               next_in  = cur_wrap;
               state_in = S_RESP;
            end else begin
               wdata  = rca_pkg::CELL_INSIDE;
               cur_in = cur_ff + IW'(1);
            end
         end
         S_FPREV: begin
            raddr    = (cur_ff == '0) ? IW'(eff_size - SW'(1)) : cur_ff - IW'(1);
            state_in = S_FCHK;
         end
         S_FCHK: begin
            if (cur_ff != next_ff && rdata_ff != rca_pkg::CELL_FREE) begin
               mark_in = rca_pkg::CELL_PREV_IN_USE;
            end else begin
               mark_in = rca_pkg::CELL_FREE;
            end
            cnt_in   = '0;
            state_in = S_FRD;
         end
         S_FRD: begin
            state_in = S_FWR;
         end
         S_FWR: begin
            we     = 1'b1;
            wdata  = mark_ff;
            cur_in = cur_wrap;
            cnt_in = cnt_inc;
            if (rdata_ff == rca_pkg::CELL_END || cnt_inc == eff_size) begin
               cnt_in   = '0;
               state_in = (mark_ff == rca_pkg::CELL_FREE) ? S_TRD : S_RESP;
            end else begin
               state_in = S_FRD;
            end
         end
         S_TRD: begin
            state_in = (cnt_ff == eff_size) ? S_RESP : S_TWR;
         end
         S_TWR: begin
            if (rdata_ff == rca_pkg::CELL_PREV_IN_USE) begin
               we       = 1'b1;
               cur_in   = cur_wrap;
               cnt_in   = cnt_inc;
               state_in = S_TRD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_start_in = res_start_ff;
               rsp_stat_in  = res_stat_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // single-port cell memory, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      last_ff      <= last_in;
      cnt_ff       <= cnt_in;
      mark_ff      <= mark_in;
      lfree_ff     <= lfree_in;
      res_start_ff <= res_start_in;
      res_stat_ff  <= res_stat_in;
      rsp_start_ff <= rsp_start_in;
      rsp_stat_ff  <= rsp_stat_in;
      if (reset) begin
         state_ff     <= S_CLEAR;
         cur_ff       <= '0;
         next_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         next_ff      <= next_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

// ----- src/rca_checker.sv -----
// rca_checker: port-level assertions for ring_cell_allocator, bound to the top
// depends on rca_pkg and ring_cell_allocator
`timescale 1ns / 1ps
module rca_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [15:0]  rsp_tdata
);
   // a waiting result is not withdrawn
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp transaction withdrawn");

   // failed requests report start 0
   a_err_start: assert property (@(posedge clock)
      rsp_tvalid && rsp_tdata[11:10] != 2'(rca_pkg::ST_OK) |-> rsp_tdata[9:0] == 10'd0)
      else $error("error result with nonzero start");

   // no result right after reset
   a_rst_rsp: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result after reset");

   // clearing pass blocks requests after reset
   a_rst_clear: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("request taken during clearing pass");
endmodule

bind ring_cell_allocator rca_checker u_rca_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
